FILE: rtl/core/ogne_pkg.sv
// ogne_pkg: shared constants, codes and command/status types of the
// occupancy grid neighbor engine. Used by ogne_ctrl, ogne_datapath and the
// top level; depends on nothing.
package ogne_pkg;

  // grid geometry and counter size
  localparam int GRID_W     = 64;
  localparam int GRID_H     = 64;
  localparam int GRID_CELLS = GRID_W * GRID_H;
  localparam int ADDR_BITS  = $clog2(GRID_CELLS);
  localparam int COUNT_BITS = 16;

  // field widths of the stream words
  localparam int X_BITS     = 6;
  localparam int Y_BITS     = 6;
  localparam int DELTA_BITS = 16;
  localparam int COST_BITS  = 4;
  localparam int SQ_BITS    = 13;
  localparam int CNT_BITS   = 16;
  localparam int IN_BITS    = 32;
  localparam int OUT_BITS   = 48;

  // signed coordinate width used for neighbor offsets
  localparam int CX_BITS = X_BITS + 2;
  localparam int CY_BITS = Y_BITS + 2;

  // move costs in tenths
  localparam logic [COST_BITS-1:0] COST_ONE = 4'd10;
  localparam logic [COST_BITS-1:0] COST_TWO = 4'd13;

  // neighbor candidate list
  localparam int NUM_CAND  = 12;
  localparam int CAND_BITS = $clog2(NUM_CAND);

  typedef enum logic [1:0] {
    KIND_CLEAR   = 2'd0,
    KIND_ADD     = 2'd1,
    KIND_NBR     = 2'd2,
    KIND_NEAREST = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ADDR_QUERY = 2'd0,
    ADDR_CAND  = 2'd1,
    ADDR_SCAN  = 2'd2
  } addr_sel_e;

  typedef enum logic {
    WR_ZERO = 1'b0,
    WR_ADD  = 1'b1
  } wr_sel_e;

  typedef enum logic [1:0] {
    RES_ZERO = 2'd0,
    RES_ADD  = 2'd1,
    RES_PEND = 2'd2,
    RES_BEST = 2'd3
  } res_sel_e;

  typedef struct packed {
    logic signed [2:0]    dx;
    logic signed [2:0]    dy;
    logic [COST_BITS-1:0] cost;
  } cand_t;

  // controller to datapath
  typedef struct packed {
    logic      load;
    logic      rd_en;
    addr_sel_e addr_sel;
    logic      wr_en;
    wr_sel_e   wr_sel;
    logic      scan_clr;
    logic      scan_inc;
    logic      scan_rd;
    logic      idx_clr;
    logic      idx_inc;
    logic      pend_clr;
    logic      pend_load;
    logic      best_clr;
    logic      push;
    res_sel_e  res_sel;
    logic      res_last;
  } ogne_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic rd_zero;
    logic cand_ok;
    logic idx_last;
    logic scan_last;
    logic pend_have;
    logic best_have;
    logic out_free;
  } ogne_sts_t;

  // candidate order: +x, +2x, +y, +2y, -x, -2x, -y, -2y, then diagonals
  function automatic cand_t cand_offset(input logic [CAND_BITS-1:0] idx);
    cand_t c;
    c = '{dx: 3'sd0, dy: 3'sd0, cost: COST_ONE};
    unique case (idx)
      4'd0:    c = '{dx:  3'sd1, dy:  3'sd0, cost: COST_ONE};
      4'd1:    c = '{dx:  3'sd2, dy:  3'sd0, cost: COST_TWO};
      4'd2:    c = '{dx:  3'sd0, dy:  3'sd1, cost: COST_ONE};
      4'd3:    c = '{dx:  3'sd0, dy:  3'sd2, cost: COST_TWO};
      4'd4:    c = '{dx: -3'sd1, dy:  3'sd0, cost: COST_ONE};
      4'd5:    c = '{dx: -3'sd2, dy:  3'sd0, cost: COST_TWO};
      4'd6:    c = '{dx:  3'sd0, dy: -3'sd1, cost: COST_ONE};
      4'd7:    c = '{dx:  3'sd0, dy: -3'sd2, cost: COST_TWO};
      4'd8:    c = '{dx:  3'sd1, dy:  3'sd1, cost: COST_ONE};
      4'd9:    c = '{dx: -3'sd1, dy:  3'sd1, cost: COST_ONE};
      4'd10:   c = '{dx: -3'sd1, dy: -3'sd1, cost: COST_ONE};
      4'd11:   c = '{dx:  3'sd1, dy: -3'sd1, cost: COST_ONE};
      default: c = '{dx:  3'sd0, dy:  3'sd0, cost: COST_ONE};
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/core/ogne_ctrl.sv
// ogne_ctrl: sequencer of the occupancy grid neighbor engine. Steps through
// clearing sweeps, add, neighbor and nearest scans. Depends on ogne_pkg.
module ogne_ctrl import ogne_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic [1:0]  in_kind_i,
  output logic        in_ready_o,
  input  ogne_sts_t   sts_i,
  output ogne_cmd_t   cmd_o
);

  typedef enum logic [3:0] {
    ST_INIT_SWEEP,
    ST_IDLE,
    ST_CLR_SWEEP,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_NB_RD0,
    ST_NB_CHK,
    ST_NB_RD,
    ST_NB_EVAL,
    ST_NB_END,
    ST_NR_SCAN,
    ST_NR_D1,
    ST_NR_D2,
    ST_NR_OUT,
    ST_EMIT_ZERO
  } state_e;

  state_e state_q, state_d;
  kind_e  kind;

  assign kind       = kind_e'(in_kind_i);
  assign in_ready_o = (state_q == ST_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_INIT_SWEEP, ST_CLR_SWEEP: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.wr_sel   = WR_ZERO;
        cmd_o.scan_inc = 1'b1;
        if (sts_i.scan_last) begin
          state_d = (state_q == ST_CLR_SWEEP) ? ST_EMIT_ZERO : ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd_o.scan_clr = 1'b1;
        cmd_o.idx_clr  = 1'b1;
        cmd_o.pend_clr = 1'b1;
        cmd_o.best_clr = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          unique case (kind)
            KIND_CLEAR:   state_d = ST_CLR_SWEEP;
            KIND_ADD:     state_d = ST_ADD_RD;
            KIND_NBR:     state_d = ST_NB_RD0;
            KIND_NEAREST: state_d = ST_NR_SCAN;
            default:      state_d = ST_IDLE;
          endcase
        end
      end
      ST_ADD_RD: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.addr_sel = ADDR_QUERY;
        state_d        = ST_ADD_WR;
      end
      ST_ADD_WR: begin
        if (sts_i.out_free) begin
          cmd_o.wr_en    = 1'b1;
          cmd_o.wr_sel   = WR_ADD;
          cmd_o.push     = 1'b1;
          cmd_o.res_sel  = RES_ADD;
          cmd_o.res_last = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_NB_RD0: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.addr_sel = ADDR_QUERY;
        state_d        = ST_NB_CHK;
      end
      ST_NB_CHK: begin
        state_d = sts_i.rd_zero ? ST_NB_RD : ST_EMIT_ZERO;
      end
      ST_NB_RD: begin
        if (sts_i.cand_ok) begin
          cmd_o.rd_en    = 1'b1;
          cmd_o.addr_sel = ADDR_CAND;
          state_d        = ST_NB_EVAL;
        end else if (sts_i.idx_last) begin
          state_d = ST_NB_END;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      ST_NB_EVAL: begin
        // a free candidate pushes out the one held before it
        if (!sts_i.rd_zero || !sts_i.pend_have || sts_i.out_free) begin
          if (sts_i.rd_zero) begin
            cmd_o.pend_load = 1'b1;
            cmd_o.push      = sts_i.pend_have;
            cmd_o.res_sel   = RES_PEND;
          end
          if (sts_i.idx_last) begin
            state_d = ST_NB_END;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = ST_NB_RD;
          end
        end
      end
      ST_NB_END: begin
        if (sts_i.out_free) begin
          cmd_o.push     = 1'b1;
          cmd_o.res_sel  = sts_i.pend_have ? RES_PEND : RES_ZERO;
          cmd_o.res_last = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_NR_SCAN: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.addr_sel = ADDR_SCAN;
        cmd_o.scan_rd  = 1'b1;
        cmd_o.scan_inc = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_NR_D1;
        end
      end
      ST_NR_D1: state_d = ST_NR_D2;
      ST_NR_D2: state_d = ST_NR_OUT;
      ST_NR_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.push     = 1'b1;
          cmd_o.res_sel  = sts_i.best_have ? RES_BEST : RES_ZERO;
          cmd_o.res_last = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_EMIT_ZERO: begin
        if (sts_i.out_free) begin
          cmd_o.push     = 1'b1;
          cmd_o.res_sel  = RES_ZERO;
          cmd_o.res_last = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state register, reset starts the clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT_SWEEP;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/core/ogne_datapath.sv
// ogne_datapath: grid counter memory, query registers, neighbor candidate
// generator, nearest-cell search pipeline and output word register.
// Depends on ogne_pkg; driven by ogne_ctrl.
module ogne_datapath import ogne_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ogne_cmd_t             cmd_i,
  output ogne_sts_t             sts_o,
  input  logic [X_BITS-1:0]     in_x_i,
  input  logic [Y_BITS-1:0]     in_y_i,
  input  logic [DELTA_BITS-1:0] in_delta_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [X_BITS-1:0]     out_x_o,
  output logic [Y_BITS-1:0]     out_y_o,
  output logic [COST_BITS-1:0]  out_cost_o,
  output logic [SQ_BITS-1:0]    out_sq_o,
  output logic [CNT_BITS-1:0]   out_cnt_o,
  output logic                  out_found_o,
  output logic                  out_last_o
);

  localparam int SUM_BITS = COUNT_BITS + 2;

  // query registers
  logic [X_BITS-1:0]     qx_q;
  logic [Y_BITS-1:0]     qy_q;
  logic [DELTA_BITS-1:0] delta_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      qx_q    <= ({1'b0, in_x_i} >= (X_BITS + 1)'(GRID_W)) ? X_BITS'(GRID_W - 1) : in_x_i;
      qy_q    <= ({1'b0, in_y_i} >= (Y_BITS + 1)'(GRID_H)) ? Y_BITS'(GRID_H - 1) : in_y_i;
      delta_q <= in_delta_i;
    end
  end

  // scan counter and candidate index
  logic [ADDR_BITS-1:0] scan_q;
  logic [CAND_BITS-1:0] idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
      idx_q  <= '0;
    end else begin
      if (cmd_i.scan_clr) begin
        scan_q <= '0;
      end else if (cmd_i.scan_inc) begin
        scan_q <= scan_q + 1'b1;
      end
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  // candidate neighbor coordinates
  cand_t                     cand;
  logic signed [CX_BITS-1:0] cand_xs;
  logic signed [CY_BITS-1:0] cand_ys;
  logic [X_BITS-1:0]         cand_x;
  logic [Y_BITS-1:0]         cand_y;
  logic                      cand_ok;

  assign cand    = cand_offset(idx_q);
  assign cand_xs = $signed({2'b00, qx_q}) + CX_BITS'(cand.dx);
  assign cand_ys = $signed({2'b00, qy_q}) + CY_BITS'(cand.dy);
  assign cand_x  = cand_xs[X_BITS-1:0];
  assign cand_y  = cand_ys[Y_BITS-1:0];
  assign cand_ok = (cand_xs >= 0) && (cand_xs < $signed(CX_BITS'(GRID_W)))
                && (cand_ys >= 0) && (cand_ys < $signed(CY_BITS'(GRID_H)));

  // memory addresses
  logic [ADDR_BITS-1:0] query_addr;
  logic [ADDR_BITS-1:0] cand_addr;
  logic [ADDR_BITS-1:0] rd_addr;
  logic [ADDR_BITS-1:0] wr_addr;

  assign query_addr = ADDR_BITS'(ADDR_BITS'(qx_q) * ADDR_BITS'(GRID_H) + ADDR_BITS'(qy_q));
  assign cand_addr  = ADDR_BITS'(ADDR_BITS'(cand_x) * ADDR_BITS'(GRID_H)
                                 + ADDR_BITS'(cand_y));

  always_comb begin
    unique case (cmd_i.addr_sel)
      ADDR_QUERY: rd_addr = query_addr;
      ADDR_CAND:  rd_addr = cand_addr;
      ADDR_SCAN:  rd_addr = scan_q;
      default:    rd_addr = query_addr;
    endcase
  end

  assign wr_addr = (cmd_i.wr_sel == WR_ADD) ? query_addr : scan_q;

  // saturating add of the signed delta
  logic [COUNT_BITS-1:0]      rdata_q;
  logic signed [SUM_BITS-1:0] sum;
  logic [COUNT_BITS-1:0]      sat_cnt;

  assign sum = $signed({2'b00, rdata_q}) + SUM_BITS'($signed(delta_q));

  always_comb begin
    if (sum < 0) begin
      sat_cnt = '0;
    end else if (sum[SUM_BITS-2:COUNT_BITS] != '0) begin
      sat_cnt = '1;
    end else begin
      sat_cnt = sum[COUNT_BITS-1:0];
    end
  end

  // grid counter memory, one write and one registered read per cycle
  logic [COUNT_BITS-1:0] mem_q [GRID_CELLS];
  logic [COUNT_BITS-1:0] wr_data;

  assign wr_data = (cmd_i.wr_sel == WR_ADD) ? sat_cnt : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // nearest search pipeline: read, distance, compare
  logic [ADDR_BITS-1:0] eval_addr_q;
  logic                 eval_v_q;
  logic [X_BITS-1:0]    ex;
  logic [Y_BITS-1:0]    ey;
  logic [X_BITS-1:0]    dx;
  logic [Y_BITS-1:0]    dy;
  logic [SQ_BITS-1:0]   sq_dist;
  logic                 s1_v_q;
  logic [X_BITS-1:0]    s1_x_q;
  logic [Y_BITS-1:0]    s1_y_q;
  logic [SQ_BITS-1:0]   s1_d_q;
  logic                 best_have_q;
  logic [X_BITS-1:0]    best_x_q;
  logic [Y_BITS-1:0]    best_y_q;
  logic [SQ_BITS-1:0]   best_d_q;

  assign ex      = X_BITS'(eval_addr_q / ADDR_BITS'(GRID_H));
  assign ey      = Y_BITS'(eval_addr_q % ADDR_BITS'(GRID_H));
  assign dx      = (ex > qx_q) ? ex - qx_q : qx_q - ex;
  assign dy      = (ey > qy_q) ? ey - qy_q : qy_q - ey;
  assign sq_dist = SQ_BITS'(dx) * SQ_BITS'(dx) + SQ_BITS'(dy) * SQ_BITS'(dy);

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      eval_addr_q <= rd_addr;
    end
    s1_x_q <= ex;
    s1_y_q <= ey;
    s1_d_q <= sq_dist;
    if (s1_v_q && (!best_have_q || (s1_d_q < best_d_q))) begin
      best_x_q <= s1_x_q;
      best_y_q <= s1_y_q;
      best_d_q <= s1_d_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eval_v_q    <= 1'b0;
      s1_v_q      <= 1'b0;
      best_have_q <= 1'b0;
    end else begin
      eval_v_q <= cmd_i.scan_rd;
      s1_v_q   <= eval_v_q && (rdata_q == '0);
      if (cmd_i.best_clr) begin
        best_have_q <= 1'b0;
      end else if (s1_v_q) begin
        best_have_q <= 1'b1;
      end
    end
  end

  // held neighbor, sent once the next one or the end is known
  logic                 pend_have_q;
  logic [X_BITS-1:0]    pend_x_q;
  logic [Y_BITS-1:0]    pend_y_q;
  logic [COST_BITS-1:0] pend_cost_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.pend_load) begin
      pend_x_q    <= cand_x;
      pend_y_q    <= cand_y;
      pend_cost_q <= cand.cost;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_have_q <= 1'b0;
    end else if (cmd_i.pend_clr) begin
      pend_have_q <= 1'b0;
    end else if (cmd_i.pend_load) begin
      pend_have_q <= 1'b1;
    end
  end

  // output word register
  logic out_valid_q;
  logic out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_x_o     <= '0;
      out_y_o     <= '0;
      out_cost_o  <= '0;
      out_sq_o    <= '0;
      out_cnt_o   <= '0;
      out_found_o <= 1'b0;
      out_last_o  <= cmd_i.res_last;
      unique case (cmd_i.res_sel)
        RES_ZERO: begin
        end
        RES_ADD: begin
          out_x_o   <= qx_q;
          out_y_o   <= qy_q;
          out_cnt_o <= CNT_BITS'(sat_cnt);
        end
        RES_PEND: begin
          out_x_o     <= pend_x_q;
          out_y_o     <= pend_y_q;
          out_cost_o  <= pend_cost_q;
          out_found_o <= 1'b1;
        end
        RES_BEST: begin
          out_x_o     <= best_x_q;
          out_y_o     <= best_y_q;
          out_sq_o    <= best_d_q;
          out_found_o <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

  // status back to the sequencer
  assign sts_o.rd_zero   = (rdata_q == '0);
  assign sts_o.cand_ok   = cand_ok;
  assign sts_o.idx_last  = (idx_q == CAND_BITS'(NUM_CAND - 1));
  assign sts_o.scan_last = (scan_q == ADDR_BITS'(GRID_CELLS - 1));
  assign sts_o.pend_have = pend_have_q;
  assign sts_o.best_have = best_have_q;
  assign sts_o.out_free  = out_free;

endmodule

FILE: rtl/core/occupancy_grid_neighbor_engine_unit.sv
// occupancy_grid_neighbor_engine_unit: top level of the occupancy grid
// neighbor engine; joins ogne_ctrl and ogne_datapath to the stream ports.
// Depends on ogne_pkg, ogne_ctrl and ogne_datapath.
//
// Keeps a 64 x 64 grid of 16-bit blocking counters in one single-port-read,
// single-port-write memory; a cell is free when its counter is zero. After
// reset the block runs a clearing pass over all cells and takes no word until
// it ends. Per input word, each step bound by the one read port of the grid
// memory: clear sweeps all 4096 cells and then gives its word; add reads the
// cell, then saturates and writes it; a neighbor query reads the query cell,
// then reads each candidate inside the grid and skips each one outside (up to
// 12 result words); a nearest-free query reads every cell once through a
// three-stage distance pipeline. One word is in work at a time; the output
// register lets a new input word be taken while the last result waits.
module occupancy_grid_neighbor_engine_unit import ogne_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // cell_x [5:0], cell_y [11:6], delta [27:12], zero fill [31:28]
  input  logic [IN_BITS-1:0]  s_axis_tdata_i,
  // kind [1:0]
  input  logic [1:0]          s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // res_x [5:0], res_y [11:6], step_cost [15:12], sq_distance [28:16],
  // cell_count [44:29], zero fill [47:45]
  output logic [OUT_BITS-1:0] m_axis_tdata_o,
  // found [0]
  output logic                m_axis_tuser_o,
  output logic                m_axis_tlast_o
);

  localparam int Y_LO  = X_BITS;
  localparam int D_LO  = Y_LO + Y_BITS;
  localparam int PACK  = X_BITS + Y_BITS + COST_BITS + SQ_BITS + CNT_BITS;

  ogne_cmd_t            cmd;
  ogne_sts_t            sts;
  logic [X_BITS-1:0]    res_x;
  logic [Y_BITS-1:0]    res_y;
  logic [COST_BITS-1:0] res_cost;
  logic [SQ_BITS-1:0]   res_sq;
  logic [CNT_BITS-1:0]  res_cnt;

  // sequencer
  ogne_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_kind_i  (s_axis_tuser_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // grid memory and arithmetic
  ogne_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_x_i      (s_axis_tdata_i[X_BITS-1:0]),
    .in_y_i      (s_axis_tdata_i[Y_LO +: Y_BITS]),
    .in_delta_i  (s_axis_tdata_i[D_LO +: DELTA_BITS]),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_x_o     (res_x),
    .out_y_o     (res_y),
    .out_cost_o  (res_cost),
    .out_sq_o    (res_sq),
    .out_cnt_o   (res_cnt),
    .out_found_o (m_axis_tuser_o),
    .out_last_o  (m_axis_tlast_o)
  );

  // result word packing
  assign m_axis_tdata_o = {{(OUT_BITS - PACK){1'b0}}, res_cnt, res_sq, res_cost, res_y, res_x};

`ifndef SYNTHESIS
  // a result is only pushed when the output register can take it
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |-> sts.out_free)
    else $error("result pushed into a full output register");

  // an accepted word takes the block out of idle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input taken twice in a row");

  // the grid memory is never read and written in the same cycle
  a_mem_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wr_en |-> !cmd.rd_en)
    else $error("grid memory read and written together");

  // no input is taken while a clearing sweep runs
  a_sweep_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.wr_en && (cmd.wr_sel == WR_ZERO)) |-> !s_axis_tready_o)
    else $error("input ready during clearing sweep");
`endif

endmodule

FILE: tb/testbench.sv
// testbench: self-checking stream test of occupancy_grid_neighbor_engine_unit.
// Keeps its own copy of the grid to predict every result word, and checks each
// one field by field. Depends on ogne_pkg and the engine RTL.
module testbench;
  import ogne_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // one expected result word
  typedef struct {
    logic [X_BITS-1:0]    x;
    logic [Y_BITS-1:0]    y;
    logic [COST_BITS-1:0] cost;
    logic [SQ_BITS-1:0]   sq;
    logic [CNT_BITS-1:0]  cnt;
    logic                 found;
    logic                 last;
  } grid_reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [IN_BITS-1:0]  s_axis_tdata = '0;
  logic [1:0]          s_axis_tuser = KIND_CLEAR;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OUT_BITS-1:0] m_axis_tdata;
  logic                m_axis_tuser;
  logic                m_axis_tlast;

  // predictor state: counter per cell, x-major like the engine's memory
  logic [COUNT_BITS-1:0] occupancy [GRID_CELLS];
  grid_reply_t           reply_q [$];
  int                    error_count = 0;

  // neighbor moves in the order the engine reports them
  int step_dx [12] = '{1, 2, 0, 0, -1, -2, 0, 0, 1, -1, -1, 1};
  int step_dy [12] = '{0, 0, 1, 2, 0, 0, -1, -2, 1, 1, -1, -1};
  bit step_far [12] = '{0, 1, 0, 1, 0, 1, 0, 1, 0, 0, 0, 0};

  // sender burst state and receiver stall pattern
  int burst_left = 0;
  int sink_cycle = 0;
  int sink_mode = 0;

  occupancy_grid_neighbor_engine_unit DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  always #10 clk = ~clk;

  initial begin
    foreach (occupancy[i]) occupancy[i] = '0;
  end

  function automatic grid_reply_t make_reply(int x, int y, int cost, int sq, int cnt,
                                             logic found);
    grid_reply_t r;
    r.x     = X_BITS'(x);
    r.y     = Y_BITS'(y);
    r.cost  = COST_BITS'(cost);
    r.sq    = SQ_BITS'(sq);
    r.cnt   = CNT_BITS'(cnt);
    r.found = found;
    r.last  = 1'b0;
    return r;
  endfunction

  function automatic bit cell_is_free(int x, int y);
    return occupancy[x * GRID_H + y] == '0;
  endfunction

  // update the grid copy and queue the words one accepted word causes
  function automatic void predict_grid_op(kind_e kind, int x, int y,
                                          logic signed [DELTA_BITS-1:0] delta);
    grid_reply_t batch [$];
    int          sum, nx, ny, d, best, bx, by;
    bit          have;
    have = 1'b0;
    best = 0;
    bx = 0;
    by = 0;
    case (kind)
      KIND_CLEAR: begin
        foreach (occupancy[i]) occupancy[i] = '0;
      end
      KIND_ADD: begin
        sum = int'(occupancy[x * GRID_H + y]) + int'(delta);
        if (sum < 0) sum = 0;
        if (sum > (1 << COUNT_BITS) - 1) sum = (1 << COUNT_BITS) - 1;
        occupancy[x * GRID_H + y] = COUNT_BITS'(sum);
        batch.insert(batch.size(), make_reply(x, y, 0, 0, sum, 1'b0));
      end
      KIND_NBR: begin
        // only a free query cell has neighbors; moves off the grid are skipped
        if (cell_is_free(x, y)) begin
          for (int k = 0; k < 12; k++) begin
            nx = x + step_dx[k];
            ny = y + step_dy[k];
            if (nx >= 0 && nx < GRID_W && ny >= 0 && ny < GRID_H && cell_is_free(nx, ny))
              batch.insert(batch.size(),
                           make_reply(nx, ny, step_far[k] ? COST_TWO : COST_ONE, 0, 0,
                                      1'b1));
          end
        end
      end
      default: begin
        // x-major scan, first strictly smaller distance wins
        for (int cx = 0; cx < GRID_W; cx++) begin
          for (int cy = 0; cy < GRID_H; cy++) begin
            if (cell_is_free(cx, cy)) begin
              d = (cx - x) * (cx - x) + (cy - y) * (cy - y);
              if (!have || d < best) begin
                have = 1'b1;
                best = d;
                bx = cx;
                by = cy;
              end
            end
          end
        end
        if (have) batch.insert(batch.size(), make_reply(bx, by, 0, best, 0, 1'b1));
      end
    endcase
    if (batch.size() == 0) batch.insert(0, make_reply(0, 0, 0, 0, 0, 1'b0));
    batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) reply_q.insert(reply_q.size(), batch[i]);
  endfunction

  // drive one word, wait for its handshake, then predict its results
  task automatic send_word(kind_e kind, int x, int y, logic [DELTA_BITS-1:0] delta);
    int         gap;
    logic [5:0] px, py;
    px = X_BITS'(x);
    py = Y_BITS'(y);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, delta, py, px};
    s_axis_tuser  <= kind;
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    predict_grid_op(kind, x, y, delta);
  endtask

  // hold the sender off until every expected word has come
  task automatic wait_for_replies();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (reply_q.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  task automatic check_reply();
    grid_reply_t want;
    if (reply_q.size() == 0) begin
      $display("%0t: result word with none expected, data %h found %b last %b",
               $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
      error_count++;
    end else begin
      want = reply_q.pop_front();
      check_field("res_x", want.x, m_axis_tdata[5:0]);
      check_field("res_y", want.y, m_axis_tdata[11:6]);
      check_field("step_cost", want.cost, m_axis_tdata[15:12]);
      check_field("sq_distance", want.sq, m_axis_tdata[28:16]);
      check_field("cell_count", want.cnt, m_axis_tdata[44:29]);
      check_field("zero fill", 0, m_axis_tdata[47:45]);
      check_field("found", want.found, m_axis_tuser);
      check_field("last", want.last, m_axis_tlast);
    end
  endtask

  // receiver: check accepted words, stall on a pattern chosen at random from four
  always @(posedge clk) begin
    if (rst_n && m_axis_tvalid && m_axis_tready) check_reply();
    if (sink_cycle % 48 == 0) sink_mode = $urandom_range(0, 3);
    sink_cycle++;
    case (sink_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      2: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= sink_cycle[1];
    endcase
  end

  // coordinates mostly near the four corners so adds and queries meet
  function automatic int rand_coord();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return $urandom_range(0, 5);
    if (sel < 8) return $urandom_range(58, 63);
    return $urandom_range(0, 63);
  endfunction

  function automatic logic [DELTA_BITS-1:0] rand_delta();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 7) return DELTA_BITS'($urandom_range(1, 3));
    if (sel < 12) return DELTA_BITS'(-int'($urandom_range(1, 3)));
    if (sel < 16) return DELTA_BITS'($urandom_range(0, 16'hFFFF));
    if (sel < 18) return 16'h7FFF;
    return 16'h8000;
  endfunction

  // fresh grid: every cell free, corners see only in-grid moves
  task automatic test_empty_grid();
    send_word(KIND_NEAREST, 0, 0, 16'h0000);
    send_word(KIND_NEAREST, 63, 63, 16'hFFFF);
    send_word(KIND_NBR, 0, 0, 16'h0000);
    send_word(KIND_NBR, 63, 63, 16'h0000);
    send_word(KIND_NBR, 1, 62, 16'h0000);
    send_word(KIND_NBR, 32, 17, 16'h0000);
  endtask

  // counter saturates at both ends
  task automatic test_add_saturation();
    send_word(KIND_ADD, 63, 63, 16'h7FFF);
    send_word(KIND_ADD, 63, 63, 16'h7FFF);
    send_word(KIND_ADD, 63, 63, 16'h7FFF);
    send_word(KIND_ADD, 63, 63, 16'h8000);
    send_word(KIND_ADD, 63, 63, 16'h8000);
    send_word(KIND_ADD, 0, 0, 16'hFFFF);
    send_word(KIND_ADD, 0, 0, 16'h0000);
  endtask

  // blocked query cell, and a four-way tie for the nearest free cell
  task automatic test_blocked_query();
    send_word(KIND_ADD, 10, 20, 16'h0001);
    send_word(KIND_NBR, 10, 20, 16'h0000);
    send_word(KIND_NEAREST, 10, 20, 16'h0000);
    send_word(KIND_NBR, 11, 20, 16'h0000);
    send_word(KIND_ADD, 10, 20, 16'hFFFF);
  endtask

  // free cell with all twelve neighbors blocked
  task automatic test_enclosed_cell();
    for (int k = 0; k < 12; k++) send_word(KIND_ADD, 30 + step_dx[k], 40 + step_dy[k], 16'h0005);
    send_word(KIND_NBR, 30, 40, 16'h0000);
    send_word(KIND_NEAREST, 30, 41, 16'h0000);
    send_word(KIND_CLEAR, 0, 0, 16'h0000);
  endtask

  // blocked corner block, the nearest free cell lies past its edge
  task automatic test_full_grid();
    for (int x = 0; x < 6; x++)
      for (int y = 0; y < 6; y++)
        send_word(KIND_ADD, x, y, DELTA_BITS'($urandom_range(1, 300)));
    send_word(KIND_NEAREST, 0, 0, 16'h0000);
    send_word(KIND_NBR, 0, 0, 16'h0000);
    send_word(KIND_ADD, 5, 5, 16'h8000);
    send_word(KIND_NEAREST, 2, 2, 16'h0000);
    send_word(KIND_NBR, 5, 5, 16'h0000);
    send_word(KIND_CLEAR, 63, 63, 16'hFFFF);
  endtask

  // mixed traffic, mostly adds and neighbor queries around the corners
  task automatic test_random_traffic();
    int sel;
    for (int i = 0; i < 160; i++) begin
      if (i == 80) wait_for_replies();
      sel = $urandom_range(0, 99);
      if (sel < 55) send_word(KIND_ADD, rand_coord(), rand_coord(), rand_delta());
      else if (sel < 88)
        send_word(KIND_NBR, rand_coord(), rand_coord(),
                  DELTA_BITS'($urandom_range(0, 16'hFFFF)));
      else if (sel < 96)
        send_word(KIND_NEAREST, rand_coord(), rand_coord(),
                  DELTA_BITS'($urandom_range(0, 16'hFFFF)));
      else send_word(KIND_CLEAR, rand_coord(), rand_coord(),
                     DELTA_BITS'($urandom_range(0, 16'hFFFF)));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_grid();
    test_add_saturation();
    test_blocked_query();
    test_enclosed_cell();
    test_full_grid();
    test_random_traffic();
    wait_for_replies();
    repeat (40) @(posedge clk);
    if (error_count == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

  // hang guard: clears and nearest scans each visit every cell of the grid
  initial begin
    #40_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule

FILE: occupancy_grid_neighbor_engine_unit.f
rtl/core/ogne_pkg.sv
rtl/core/ogne_ctrl.sv
rtl/core/ogne_datapath.sv
rtl/core/occupancy_grid_neighbor_engine_unit.sv
tb/testbench.sv
